// ===== hw/rtl/ecnpq_pkg.sv =====
`timescale 1ns / 1ps

package ecnpq_pkg;

    // Width of the configuration registers and their data port.
    localparam int CFG_W = 11;

    // Register indexes on the configuration port.
    localparam logic REG_MAX_DATA_LENGTH = 1'b0;
    localparam logic REG_MARK_THRESHOLD  = 1'b1;

    // Register values after reset.
    localparam logic [CFG_W-1:0] MAX_DATA_LENGTH_RESET = 11'd1000;
    localparam logic [CFG_W-1:0] MARK_THRESHOLD_RESET  = 11'd35;

    // Result status codes.
    localparam logic [2:0] ST_SEND     = 3'd0;
    localparam logic [2:0] ST_QUEUED   = 3'd1;
    localparam logic [2:0] ST_DROPPED  = 3'd2;
    localparam logic [2:0] ST_DEQUEUED = 3'd3;
    localparam logic [2:0] ST_EMPTY    = 3'd4;

    // Where the handle of a result comes from in the second stage.
    typedef logic [1:0] t_src;
    localparam t_src SRC_NONE = 2'd0;
    localparam t_src SRC_DATA = 2'd1;
    localparam t_src SRC_MGMT = 2'd2;

endpackage

// ===== hw/rtl/ecn_marking_priority_queue_core.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake                  Payload
// in        input      i_in_valid / o_in_stall    action, handle, class, must_queue
// out       output     o_out_valid / i_out_stall  status, mark, handle, class
// cfg       input      i_cfg_valid / o_cfg_ready  register index, write data
//
// One word is taken per cycle while o_in_stall is low. Its result passes the
// first stage register and then the output register before it is on the output.
// The first stage decides and issues the FIFO memory access, the output
// register merges in the memory read data.
// Reset is synchronous and active low; the FIFO memories are not cleared.
// A stall on the output holds the output register; the input channel stalls
// only once the first stage holds a word as well.

module ecn_marking_priority_queue_core #(
    parameter int DATA_DEPTH  = 1024,
    parameter int MGMT_DEPTH  = 64,
    parameter int HANDLE_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,

    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic                      i_action,
    input  logic [HANDLE_BITS-1:0]    i_packet_handle,
    input  logic                      i_is_management,
    input  logic                      i_must_queue,

    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [2:0]                o_status,
    output logic                      o_congestion_mark,
    output logic [HANDLE_BITS-1:0]    o_handle_out,
    output logic                      o_from_management,

    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic                      i_cfg_index,
    input  logic [ecnpq_pkg::CFG_W-1:0] i_cfg_data
);

    import ecnpq_pkg::*;

    localparam int DA   = $clog2(DATA_DEPTH);
    localparam int MA   = $clog2(MGMT_DEPTH);
    localparam int DCW  = $clog2(DATA_DEPTH + 1);
    localparam int MCW  = $clog2(MGMT_DEPTH + 1);
    localparam int CMPW = (DCW > CFG_W) ? DCW : CFG_W;

    localparam logic [DA-1:0]  D_LAST = DA'(DATA_DEPTH - 1);
    localparam logic [MA-1:0]  M_LAST = MA'(MGMT_DEPTH - 1);
    localparam logic [DCW-1:0] D_FULL = DCW'(DATA_DEPTH);
    localparam logic [MCW-1:0] M_FULL = MCW'(MGMT_DEPTH);

    // FIFO memories: data entries carry the mark above the handle.
    logic [HANDLE_BITS:0]   r_d_mem [DATA_DEPTH];
    logic [HANDLE_BITS-1:0] r_m_mem [MGMT_DEPTH];
    logic [HANDLE_BITS:0]   r_d_rdata;
    logic [HANDLE_BITS-1:0] r_m_rdata;

    // FIFO pointers and fill counts.
    logic [DA-1:0]  r_d_head, n_d_head, r_d_tail, n_d_tail;
    logic [DCW-1:0] r_d_count, n_d_count;
    logic [MA-1:0]  r_m_head, n_m_head, r_m_tail, n_m_tail;
    logic [MCW-1:0] r_m_count, n_m_count;

    // Configuration registers.
    logic [CFG_W-1:0] r_max_len, r_thresh;

    // First stage: decided result, handle source pending the memory read.
    logic                   r_s1_valid;
    logic [2:0]             r_s1_status, n_s1_status;
    logic                   r_s1_mark, n_s1_mark;
    logic [HANDLE_BITS-1:0] r_s1_handle, n_s1_handle;
    logic                   r_s1_from_m, n_s1_from_m;
    t_src                   r_s1_src, n_s1_src;

    // Output register.
    logic                   r_out_valid;
    logic [2:0]             r_out_status;
    logic                   r_out_mark;
    logic [HANDLE_BITS-1:0] r_out_handle;
    logic                   r_out_from_m;

    logic out_free, s1_move, in_accept;
    logic d_we, d_re, m_we, m_re, mark;

    assign out_free  = !r_out_valid || !i_out_stall;
    assign s1_move   = r_s1_valid && out_free;
    assign o_in_stall = r_s1_valid && !out_free;
    assign in_accept = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    assign mark = CMPW'(r_d_count) > CMPW'(r_thresh);

    // Enqueue and dequeue decision on the accepted word.
    always_comb begin
        n_d_head    = r_d_head;
        n_d_tail    = r_d_tail;
        n_d_count   = r_d_count;
        n_m_head    = r_m_head;
        n_m_tail    = r_m_tail;
        n_m_count   = r_m_count;
        n_s1_status = ST_EMPTY;
        n_s1_mark   = 1'b0;
        n_s1_handle = '0;
        n_s1_from_m = 1'b0;
        n_s1_src    = SRC_NONE;
        d_we = 1'b0;
        d_re = 1'b0;
        m_we = 1'b0;
        m_re = 1'b0;
        if (in_accept) begin
            if (i_action) begin
                if (r_m_count != '0) begin
                    m_re        = 1'b1;
                    n_m_head    = (r_m_head == M_LAST) ? '0 : r_m_head + 1'b1;
                    n_m_count   = r_m_count - 1'b1;
                    n_s1_status = ST_DEQUEUED;
                    n_s1_from_m = 1'b1;
                    n_s1_src    = SRC_MGMT;
                end else if (r_d_count != '0) begin
                    d_re        = 1'b1;
                    n_d_head    = (r_d_head == D_LAST) ? '0 : r_d_head + 1'b1;
                    n_d_count   = r_d_count - 1'b1;
                    n_s1_status = ST_DEQUEUED;
                    n_s1_src    = SRC_DATA;
                end else begin
                    n_s1_status = ST_EMPTY;
                end
            end else if (i_is_management) begin
                if (!i_must_queue && r_m_count == '0) begin
                    n_s1_status = ST_SEND;
                    n_s1_handle = i_packet_handle;
                end else if (r_m_count == M_FULL) begin
                    n_s1_status = ST_DROPPED;
                end else begin
                    m_we        = 1'b1;
                    n_m_tail    = (r_m_tail == M_LAST) ? '0 : r_m_tail + 1'b1;
                    n_m_count   = r_m_count + 1'b1;
                    n_s1_status = ST_QUEUED;
                end
            end else if (CMPW'(r_d_count) >= CMPW'(r_max_len) || r_d_count == D_FULL) begin
                n_s1_status = ST_DROPPED;
            end else if (!i_must_queue && r_d_count == '0) begin
                n_s1_status = ST_SEND;
                n_s1_mark   = mark;
                n_s1_handle = i_packet_handle;
            end else begin
                d_we        = 1'b1;
                n_d_tail    = (r_d_tail == D_LAST) ? '0 : r_d_tail + 1'b1;
                n_d_count   = r_d_count + 1'b1;
                n_s1_status = ST_QUEUED;
                n_s1_mark   = mark;
            end
        end
    end

    // Data FIFO memory.
    always_ff @(posedge i_clk) begin
        if (d_we) begin
            r_d_mem[r_d_tail] <= {mark, i_packet_handle};
        end
        if (d_re) begin
            r_d_rdata <= r_d_mem[r_d_head];
        end
    end

    // Management FIFO memory.
    always_ff @(posedge i_clk) begin
        if (m_we) begin
            r_m_mem[r_m_tail] <= i_packet_handle;
        end
        if (m_re) begin
            r_m_rdata <= r_m_mem[r_m_head];
        end
    end

    // Pointers, counts, configuration and stage valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_head    <= '0;
            r_d_tail    <= '0;
            r_d_count   <= '0;
            r_m_head    <= '0;
            r_m_tail    <= '0;
            r_m_count   <= '0;
            r_max_len   <= MAX_DATA_LENGTH_RESET;
            r_thresh    <= MARK_THRESHOLD_RESET;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_d_head  <= n_d_head;
            r_d_tail  <= n_d_tail;
            r_d_count <= n_d_count;
            r_m_head  <= n_m_head;
            r_m_tail  <= n_m_tail;
            r_m_count <= n_m_count;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_MAX_DATA_LENGTH: r_max_len <= i_cfg_data;
                    REG_MARK_THRESHOLD:  r_thresh  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // First stage payload.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_status <= n_s1_status;
            r_s1_mark   <= n_s1_mark;
            r_s1_handle <= n_s1_handle;
            r_s1_from_m <= n_s1_from_m;
            r_s1_src    <= n_s1_src;
        end
    end

    // Output register: merge the memory read data into the result.
    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_status <= r_s1_status;
            r_out_from_m <= r_s1_from_m;
            unique case (r_s1_src)
                SRC_DATA: begin
                    r_out_mark   <= r_d_rdata[HANDLE_BITS];
                    r_out_handle <= r_d_rdata[HANDLE_BITS-1:0];
                end
                SRC_MGMT: begin
                    r_out_mark   <= 1'b0;
                    r_out_handle <= r_m_rdata;
                end
                default: begin
                    r_out_mark   <= r_s1_mark;
                    r_out_handle <= r_s1_handle;
                end
            endcase
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_out_status;
    assign o_congestion_mark = r_out_mark;
    assign o_handle_out      = r_out_handle;
    assign o_from_management = r_out_from_m;

endmodule

// ===== dv/tb_ecn_marking_priority_queue_core.sv =====
`timescale 1ns / 1ps

module tb_ecn_marking_priority_queue_core;
    import ecnpq_pkg::*;

    localparam int DATA_DEPTH  = 1024;
    localparam int MGMT_DEPTH  = 64;
    localparam int HANDLE_BITS = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int IDLE_PCT    = 13;
    localparam int MAX_REPORTS = 10;

    // Request codes on the action field.
    localparam logic ACT_ENQUEUE = 1'b0;
    localparam logic ACT_DEQUEUE = 1'b1;

    typedef struct packed {
        logic                   action;
        logic [HANDLE_BITS-1:0] handle;
        logic                   mgmt;
        logic                   must;
    } t_request;

    typedef struct packed {
        logic [2:0]             status;
        logic                   mark;
        logic [HANDLE_BITS-1:0] handle;
        logic                   from_mgmt;
    } t_outcome;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_stall;
    logic                   i_action = 1'b0;
    logic [HANDLE_BITS-1:0] i_packet_handle = '0;
    logic                   i_is_management = 1'b0;
    logic                   i_must_queue = 1'b0;
    logic                   o_out_valid;
    logic                   i_out_stall = 1'b0;
    logic [2:0]             o_status;
    logic                   o_congestion_mark;
    logic [HANDLE_BITS-1:0] o_handle_out;
    logic                   o_from_management;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic                   i_cfg_index = REG_MAX_DATA_LENGTH;
    logic [CFG_W-1:0]       i_cfg_data = '0;

    // Words waiting to be sent, the word on the bus, and outcomes not yet seen.
    t_request request_q[$];
    t_request on_bus;
    t_outcome outcome_q[$];

    // Shadow of the queue state and registers.
    logic [HANDLE_BITS:0]   data_fifo[$];
    logic [HANDLE_BITS-1:0] mgmt_fifo[$];
    logic [CFG_W-1:0]       drop_limit = MAX_DATA_LENGTH_RESET;
    logic [CFG_W-1:0]       mark_limit = MARK_THRESHOLD_RESET;

    int       cycle_count = 0;
    int       error_count = 0;
    logic     calm = 1'b0;
    t_outcome seen;
    t_outcome wanted;

    ecn_marking_priority_queue_core #(
        .DATA_DEPTH (DATA_DEPTH),
        .MGMT_DEPTH (MGMT_DEPTH),
        .HANDLE_BITS(HANDLE_BITS)
    ) u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_action         (i_action),
        .i_packet_handle  (i_packet_handle),
        .i_is_management  (i_is_management),
        .i_must_queue     (i_must_queue),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_status         (o_status),
        .o_congestion_mark(o_congestion_mark),
        .o_handle_out     (o_handle_out),
        .o_from_management(o_from_management),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Work out the outcome of one accepted request and update the shadow queues.
    function automatic t_outcome queue_outcome(t_request req);
        t_outcome             res;
        logic [HANDLE_BITS:0] entry;
        int                   depth;
        logic                 mark;
        res = '{status: ST_EMPTY, mark: 1'b0, handle: '0, from_mgmt: 1'b0};
        depth = data_fifo.size();
        if (req.action == ACT_DEQUEUE) begin
            if (mgmt_fifo.size() > 0) begin
                res.status    = ST_DEQUEUED;
                res.handle    = mgmt_fifo.pop_front();
                res.from_mgmt = 1'b1;
            end else if (depth > 0) begin
                entry       = data_fifo.pop_front();
                res.status  = ST_DEQUEUED;
                res.mark    = entry[HANDLE_BITS];
                res.handle  = entry[HANDLE_BITS-1:0];
            end
        end else if (req.mgmt) begin
            if (!req.must && mgmt_fifo.size() == 0) begin
                res.status = ST_SEND;
                res.handle = req.handle;
            end else if (mgmt_fifo.size() >= MGMT_DEPTH) begin
                res.status = ST_DROPPED;
            end else begin
                mgmt_fifo.push_back(req.handle);
                res.status = ST_QUEUED;
            end
        end else if (depth >= drop_limit || depth >= DATA_DEPTH) begin
            res.status = ST_DROPPED;
        end else begin
            mark     = (depth > mark_limit);
            res.mark = mark;
            if (!req.must && depth == 0) begin
                res.status = ST_SEND;
                res.handle = req.handle;
            end else begin
                data_fifo.push_back({mark, req.handle});
                res.status = ST_QUEUED;
            end
        end
        return res;
    endfunction

    function automatic t_request random_request(int enq_pct, int mgmt_pct, int must_pct);
        t_request req;
        req.action = ($urandom_range(0, 99) < enq_pct) ? ACT_ENQUEUE : ACT_DEQUEUE;
        req.handle = HANDLE_BITS'($urandom_range(0, (1 << HANDLE_BITS) - 1));
        req.mgmt   = ($urandom_range(0, 99) < mgmt_pct);
        req.must   = ($urandom_range(0, 99) < must_pct);
        return req;
    endfunction

    task automatic add_request(logic action, logic [HANDLE_BITS-1:0] handle,
                               logic mgmt, logic must);
        request_q.push_back('{action: action, handle: handle, mgmt: mgmt, must: must});
    endtask

    // Block until every word is sent and every outcome has come back.
    task automatic wait_drained();
        while (request_q.size() != 0 || i_in_valid || outcome_q.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(logic index, logic [CFG_W-1:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (index == REG_MAX_DATA_LENGTH)
            drop_limit = value;
        else
            mark_limit = value;
    endtask

    task automatic random_phase(int count, int enq_pct, int mgmt_pct, int must_pct);
        repeat (count)
            request_q.push_back(random_request(enq_pct, mgmt_pct, must_pct));
        wait_drained();
    endtask

    // Input driver: hold a stalled word, otherwise send the next one or idle.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall)
                outcome_q.push_back(queue_outcome(on_bus));
            if (i_in_valid && o_in_stall) begin
                i_in_valid <= 1'b1;
            end else if (request_q.size() != 0
                         && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
                on_bus          = request_q.pop_front();
                i_in_valid      <= 1'b1;
                i_action        <= on_bus.action;
                i_packet_handle <= on_bus.handle;
                i_is_management <= on_bus.mgmt;
                i_must_queue    <= on_bus.must;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Output monitor: compare each accepted word with the oldest outcome.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL ecn_marking_priority_queue_core");
            $finish;
        end else begin
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                seen = '{status: o_status, mark: o_congestion_mark,
                         handle: o_handle_out, from_mgmt: o_from_management};
                if (outcome_q.size() == 0) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("Unexpected word: status %0d mark %0d handle %h mgmt %0d",
                                 seen.status, seen.mark, seen.handle, seen.from_mgmt);
                end else begin
                    wanted = outcome_q.pop_front();
                    if (seen != wanted) begin
                        error_count++;
                        if (error_count <= MAX_REPORTS) begin
                            $write("Mismatch at cycle %0d (status/mark/handle/mgmt): ",
                                   cycle_count);
                            $display("expected %0d/%0d/%h/%0d, got %0d/%0d/%h/%0d",
                                     wanted.status, wanted.mark, wanted.handle,
                                     wanted.from_mgmt, seen.status, seen.mark,
                                     seen.handle, seen.from_mgmt);
                        end
                    end
                end
            end
            i_out_stall <= i_rst_n && !calm && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed words with the reset register values.
        add_request(ACT_DEQUEUE, 16'hFFFF, 1'b1, 1'b1);  // empty dequeue
        add_request(ACT_ENQUEUE, 16'hFFFF, 1'b1, 1'b0);  // management sent at once
        add_request(ACT_ENQUEUE, 16'h0000, 1'b0, 1'b0);  // data sent at once
        add_request(ACT_ENQUEUE, 16'hFFFF, 1'b0, 1'b1);  // data forced into the queue
        add_request(ACT_ENQUEUE, 16'h1234, 1'b0, 1'b0);  // data queued behind it
        add_request(ACT_ENQUEUE, 16'h0000, 1'b1, 1'b1);  // management forced into the queue
        add_request(ACT_ENQUEUE, 16'hABCD, 1'b1, 1'b0);  // management queued behind it
        add_request(ACT_DEQUEUE, 16'h0000, 1'b0, 1'b0);  // management is served first
        add_request(ACT_DEQUEUE, 16'h5555, 1'b0, 1'b1);
        add_request(ACT_DEQUEUE, 16'hAAAA, 1'b1, 1'b0);
        add_request(ACT_DEQUEUE, 16'hFFFF, 1'b1, 1'b1);
        add_request(ACT_DEQUEUE, 16'h0000, 1'b0, 1'b0);  // empty again
        add_request(ACT_ENQUEUE, 16'h8001, 1'b0, 1'b1);
        add_request(ACT_ENQUEUE, 16'h7FFE, 1'b1, 1'b1);
        add_request(ACT_DEQUEUE, 16'h0000, 1'b0, 1'b0);
        add_request(ACT_DEQUEUE, 16'h0000, 1'b0, 1'b0);
        add_request(ACT_DEQUEUE, 16'h0000, 1'b0, 1'b0);
        wait_drained();

        // A zero length limit drops every data packet.
        write_reg(REG_MAX_DATA_LENGTH, 11'd0);
        write_reg(REG_MARK_THRESHOLD, 11'd0);
        random_phase(20, 70, 30, 50);

        // Fill the data queue past its depth with the largest limit, then empty it.
        write_reg(REG_MAX_DATA_LENGTH, 11'h7FF);
        write_reg(REG_MARK_THRESHOLD, 11'd1000);
        repeat (DATA_DEPTH + 3)
            add_request(ACT_ENQUEUE, HANDLE_BITS'($urandom_range(0, 16'hFFFF)), 1'b0, 1'b1);
        wait_drained();
        repeat (DATA_DEPTH + 8)
            request_q.push_back(random_request(0, 50, 50));
        wait_drained();

        // Random phases across a spread of limits.
        write_reg(REG_MAX_DATA_LENGTH, 11'd1);
        random_phase(30, 60, 30, 50);
        write_reg(REG_MAX_DATA_LENGTH, 11'd1024);
        write_reg(REG_MARK_THRESHOLD, 11'h7FF);
        random_phase(30, 65, 20, 50);
        write_reg(REG_MAX_DATA_LENGTH, 11'd16);
        write_reg(REG_MARK_THRESHOLD, 11'd4);
        random_phase(40, 60, 30, 60);

        // Management-heavy traffic fills its queue and forces drops.
        write_reg(REG_MAX_DATA_LENGTH, 11'h7FF);
        write_reg(REG_MARK_THRESHOLD, 11'd20);
        random_phase(120, 90, 90, 60);

        // A stretch with no idling on either side.
        calm = 1'b1;
        write_reg(REG_MAX_DATA_LENGTH, 11'd40);
        write_reg(REG_MARK_THRESHOLD, 11'd0);
        random_phase(50, 55, 30, 50);
        calm = 1'b0;

        write_reg(REG_MAX_DATA_LENGTH, MAX_DATA_LENGTH_RESET);
        write_reg(REG_MARK_THRESHOLD, MARK_THRESHOLD_RESET);
        random_phase(40, 45, 30, 50);

        write_reg(REG_MAX_DATA_LENGTH, CFG_W'($urandom_range(1, 64)));
        write_reg(REG_MARK_THRESHOLD, CFG_W'($urandom_range(0, 64)));
        random_phase(30, 55, 30, 50);

        // Let any stray word surface before the verdict.
        repeat (10) @(posedge i_clk);
        if (error_count == 0 && outcome_q.size() == 0) begin
            $display("PASS ecn_marking_priority_queue_core");
        end else begin
            $display("FAIL ecn_marking_priority_queue_core");
        end
        $finish;
    end

endmodule
